// ===== design/wildcard_byte_pattern_scanner_assert.svh =====
// assertion macros for the wildcard byte pattern scanner checker
// no dependencies; included by the checker file only
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH

// same-cycle implication, sampled on the rising edge, off during reset
`define WBPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wbps assertion failed");

// next-cycle implication, sampled on the rising edge, off during reset
`define WBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wbps assertion failed");

`endif

// ===== design/wbps_pkg.sv =====
// shared types and constants for the wildcard byte pattern scanner
// no dependencies; used by every module of the block
package wbps_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int ADDR_BITS_DEF   = 48;

  localparam int PAT_BYTES  = 16;
  localparam int PAT_W      = 8 * PAT_BYTES;
  localparam int CARE_W     = 16;
  localparam int LEN_W      = 5;
  localparam int COUNT_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_CARE_MASK    = 3'd2,
    REG_PATTERN_LEN  = 3'd3,
    REG_MATCH_LIMIT  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [PAT_W-1:0]   pattern;
    logic [CARE_W-1:0]  care;
    logic [LEN_W-1:0]   length;
    logic [COUNT_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic scan_start;
    logic region_start;
  } flags_t;

endpackage

// ===== design/wbps_cfg.sv =====
// configuration register file of the wildcard byte pattern scanner
// depends on wbps_pkg
module wbps_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]    wr_data,
  output wbps_pkg::cfg_t                     cfg
);

  wbps_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern <= '0;
      cfg_r.care    <= '1;
      cfg_r.length  <= wbps_pkg::LEN_W'(1);
      cfg_r.limit   <= wbps_pkg::COUNT_W'(1);
    end else if (wr_en) begin
      case (wr_index)
        wbps_pkg::REG_PATTERN_LOW:  cfg_r.pattern[63:0]   <= wr_data;
        wbps_pkg::REG_PATTERN_HIGH: cfg_r.pattern[127:64] <= wr_data;
        wbps_pkg::REG_CARE_MASK:    cfg_r.care   <= wr_data[wbps_pkg::CARE_W-1:0];
        wbps_pkg::REG_PATTERN_LEN:  cfg_r.length <= wr_data[wbps_pkg::LEN_W-1:0];
        wbps_pkg::REG_MATCH_LIMIT:  cfg_r.limit  <= wr_data[wbps_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/wbps_in_reg.sv =====
// input register stage of the wildcard byte pattern scanner
// depends on wbps_pkg; holds one beat until the scan stage takes it
module wbps_in_reg #(
  parameter int ADDR_BITS = wbps_pkg::ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s_valid,
  output logic                 s_ready,
  input  logic [7:0]           s_byte,
  input  logic [ADDR_BITS-1:0] s_addr,
  input  wbps_pkg::flags_t     s_flags,
  input  logic                 take,
  output logic                 q_valid,
  output logic [7:0]           q_byte,
  output logic [ADDR_BITS-1:0] q_addr,
  output wbps_pkg::flags_t     q_flags
);

  logic                 vld_r;
  logic                 vld_nxt;
  logic [7:0]           byte_r;
  logic [ADDR_BITS-1:0] addr_r;
  wbps_pkg::flags_t     flags_r;

  // free slot, or the held beat leaves this cycle
  assign s_ready = !vld_r || take;

  always_comb begin
    vld_nxt = vld_r;
    if (s_valid && s_ready) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      byte_r  <= s_byte;
      addr_r  <= s_addr;
      flags_r <= s_flags;
    end
  end

  assign q_valid = vld_r;
  assign q_byte  = byte_r;
  assign q_addr  = addr_r;
  assign q_flags = flags_r;

endmodule

// ===== design/wbps_match.sv =====
// masked parallel compare of the window against the pattern
// depends on wbps_pkg; window entry 0 is the newest byte
module wbps_match #(
  parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
  parameter int FILL_W      = $clog2(MAX_PATTERN + 1)
) (
  input  logic [MAX_PATTERN-1:0][7:0] win,
  input  wbps_pkg::cfg_t              cfg,
  input  logic [FILL_W-1:0]           len,
  output logic                        ok
);

  logic [wbps_pkg::PAT_BYTES-1:0][7:0] sel_byte;

  // pattern byte k lines up with window entry len-1-k
  always_comb begin
    sel_byte = '0;
    for (int k = 0; k < wbps_pkg::PAT_BYTES; k++) begin
      for (int d = 0; d < MAX_PATTERN; d++) begin
        if (d + k + 1 == int'(len)) begin
          sel_byte[k] = win[d];
        end
      end
    end
  end

  always_comb begin
    ok = 1'b1;
    for (int k = 0; k < wbps_pkg::PAT_BYTES; k++) begin
      if (k < int'(len) && cfg.care[k] && sel_byte[k] != cfg.pattern[8*k +: 8]) begin
        ok = 1'b0;
      end
    end
  end

endmodule

// ===== design/wbps_scan.sv =====
// scan stage: window, fill count, match counters and result register
// depends on wbps_pkg and wbps_match
module wbps_scan #(
  parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
  parameter int ADDR_BITS   = wbps_pkg::ADDR_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  wbps_pkg::cfg_t                   cfg,
  input  logic                             in_valid,
  input  logic [7:0]                       in_byte,
  input  logic [ADDR_BITS-1:0]             in_addr,
  input  wbps_pkg::flags_t                 in_flags,
  output logic                             take,
  input  logic                             res_ready,
  output logic                             res_valid,
  output logic                             res_match_here,
  output logic [ADDR_BITS-1:0]             res_match_addr,
  output logic [wbps_pkg::COUNT_W-1:0]     res_count,
  output logic [ADDR_BITS-1:0]             res_first_addr,
  output logic                             res_first_valid,
  output logic                             res_limit_reached
);

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);

  logic [MAX_PATTERN-1:0][7:0]   win_r;
  logic [MAX_PATTERN-1:0][7:0]   win_nxt;
  logic [MAX_PATTERN-1:0][7:0]   win_sh;
  logic [FILL_W-1:0]             fill_r;
  logic [FILL_W-1:0]             fill_nxt;
  logic [wbps_pkg::COUNT_W-1:0]  cnt_r;
  logic [wbps_pkg::COUNT_W-1:0]  cnt_nxt;
  logic [ADDR_BITS-1:0]          first_r;
  logic [ADDR_BITS-1:0]          first_nxt;

  logic                          out_vld_r;
  logic                          out_vld_nxt;
  logic                          hit_r;
  logic [ADDR_BITS-1:0]          maddr_r;
  logic [wbps_pkg::COUNT_W-1:0]  ocnt_r;
  logic [ADDR_BITS-1:0]          ofirst_r;
  logic                          ofv_r;
  logic                          olim_r;

  logic [FILL_W-1:0]             len;
  logic [wbps_pkg::COUNT_W-1:0]  limit;
  logic [wbps_pkg::COUNT_W-1:0]  cnt0;
  logic [FILL_W-1:0]             fill0;
  logic [FILL_W-1:0]             fill_inc;
  logic [ADDR_BITS-1:0]          first0;
  logic                          active;
  logic                          cmp_ok;
  logic                          hit;
  logic [ADDR_BITS-1:0]          hit_addr;

  // advance when the result register is free or drains this cycle
  assign take = in_valid && (!out_vld_r || res_ready);

  always_comb begin
    if (int'(cfg.length) > MAX_PATTERN) begin
      len = FILL_W'(MAX_PATTERN);
    end else begin
      len = FILL_W'(cfg.length);
    end
  end

  assign limit = (cfg.limit == '0) ? wbps_pkg::COUNT_W'(1) : cfg.limit;

  // start flags clear state ahead of this byte
  assign cnt0   = in_flags.scan_start ? '0 : cnt_r;
  assign first0 = in_flags.scan_start ? '0 : first_r;
  assign fill0  = (in_flags.scan_start || in_flags.region_start) ? '0 : fill_r;
  assign active = cnt0 < limit;

  always_comb begin
    win_sh[0] = in_byte;
    for (int d = 1; d < MAX_PATTERN; d++) begin
      win_sh[d] = win_r[d-1];
    end
  end

  assign fill_inc = (int'(fill0) < MAX_PATTERN) ? fill0 + FILL_W'(1) : fill0;

  wbps_match #(
    .MAX_PATTERN (MAX_PATTERN),
    .FILL_W      (FILL_W)
  ) u_match (
    .win (win_sh),
    .cfg (cfg),
    .len (len),
    .ok  (cmp_ok)
  );

  assign hit      = active && (len != '0) && (fill_inc >= len) && cmp_ok;
  assign hit_addr = hit ? (in_addr - (ADDR_BITS'(len) - ADDR_BITS'(1))) : '0;

  always_comb begin
    cnt_nxt   = cnt0;
    first_nxt = first0;
    fill_nxt  = fill0;
    win_nxt   = win_r;
    if (active) begin
      win_nxt  = win_sh;
      fill_nxt = fill_inc;
    end
    if (hit) begin
      cnt_nxt  = cnt0 + wbps_pkg::COUNT_W'(1);
      fill_nxt = '0;
      if (cnt0 == '0) begin
        first_nxt = hit_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      fill_r  <= '0;
      cnt_r   <= '0;
      first_r <= '0;
    end else if (take) begin
      win_r   <= win_nxt;
      fill_r  <= fill_nxt;
      cnt_r   <= cnt_nxt;
      first_r <= first_nxt;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (take) begin
      out_vld_nxt = 1'b1;
    end else if (res_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hit_r    <= hit;
      maddr_r  <= hit_addr;
      ocnt_r   <= cnt_nxt;
      ofirst_r <= first_nxt;
      ofv_r    <= cnt_nxt != '0;
      olim_r   <= cnt_nxt >= limit;
    end
  end

  assign res_valid         = out_vld_r;
  assign res_match_here    = hit_r;
  assign res_match_addr    = maddr_r;
  assign res_count         = ocnt_r;
  assign res_first_addr    = ofirst_r;
  assign res_first_valid   = ofv_r;
  assign res_limit_reached = olim_r;

endmodule

// ===== design/wildcard_byte_pattern_scanner.sv =====
// top level of the wildcard byte pattern scanner
// depends on wbps_pkg, wbps_cfg, wbps_in_reg, wbps_scan
//
// Usage: each in_ beat carries one byte and its address (tdata) plus the
// region_start and scan_start flags (tuser). Every accepted beat gives exactly
// one out_ beat: a match flag, the start address of a match ending at this
// byte, the running match count, the first match address and status flags.
// Configuration goes through the cfg_ channel (index, 64-bit data), which is
// always ready; write it only while no beats are in flight.
// Throughput: one beat per cycle while out_ is not stalled, set by the window shift
// and parallel masked compare, done combinationally between the input register and the result register.
// Path: an accepted beat passes the input register, then the result register, to out_.
// Reset: configuration returns to pattern zero, all bytes cared, length one,
// limit one; window, fill count, match count and first address clear.
// When the receiver stalls the result register holds its beat; the input register
// takes a beat only while it is empty, then in_tready stays low until out_ drains.
module wildcard_byte_pattern_scanner #(
  parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
  parameter int ADDR_BITS   = wbps_pkg::ADDR_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // data_byte, byte_address, zero pad
  input  logic [((8 + ADDR_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // region_start, scan_start
  input  logic [1:0]                             in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // match_address, match_count, first_address, zero pad
  output logic [((2 * ADDR_BITS + 16 + 7) / 8) * 8 - 1:0] out_tdata,
  // match_here, first_valid, limit_reached
  output logic [2:0]                             out_tuser,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int OUT_TDATA_W = ((2 * ADDR_BITS + 16 + 7) / 8) * 8;

  wbps_pkg::cfg_t               cfg;
  wbps_pkg::flags_t             s_flags;
  wbps_pkg::flags_t             q_flags;
  logic                         q_valid;
  logic [7:0]                   q_byte;
  logic [ADDR_BITS-1:0]         q_addr;
  logic                         take;
  logic                         match_here;
  logic [ADDR_BITS-1:0]         match_addr;
  logic [wbps_pkg::COUNT_W-1:0] match_count;
  logic [ADDR_BITS-1:0]         first_addr;
  logic                         first_valid;
  logic                         limit_reached;

  assign cfg_ready = 1'b1;

  wbps_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign s_flags.region_start = in_tuser[0];
  assign s_flags.scan_start   = in_tuser[1];

  wbps_in_reg #(
    .ADDR_BITS (ADDR_BITS)
  ) u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_byte  (in_tdata[7:0]),
    .s_addr  (in_tdata[8 +: ADDR_BITS]),
    .s_flags (s_flags),
    .take    (take),
    .q_valid (q_valid),
    .q_byte  (q_byte),
    .q_addr  (q_addr),
    .q_flags (q_flags)
  );

  wbps_scan #(
    .MAX_PATTERN (MAX_PATTERN),
    .ADDR_BITS   (ADDR_BITS)
  ) u_scan (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_valid          (q_valid),
    .in_byte           (q_byte),
    .in_addr           (q_addr),
    .in_flags          (q_flags),
    .take              (take),
    .res_ready         (out_tready),
    .res_valid         (out_tvalid),
    .res_match_here    (match_here),
    .res_match_addr    (match_addr),
    .res_count         (match_count),
    .res_first_addr    (first_addr),
    .res_first_valid   (first_valid),
    .res_limit_reached (limit_reached)
  );

  assign out_tdata = OUT_TDATA_W'({first_addr, match_count, match_addr});
  assign out_tuser = {limit_reached, first_valid, match_here};

endmodule

// ===== design/wbps_check.sv =====
// port-level checker for the wildcard byte pattern scanner, bound to the top
// depends on wildcard_byte_pattern_scanner_assert.svh and wbps_pkg
`include "wildcard_byte_pattern_scanner_assert.svh"

module wbps_check #(
  parameter int ADDR_BITS = wbps_pkg::ADDR_BITS_DEF
) (
  input logic                                        clk,
  input logic                                        rst_n,
  input logic                                        out_tvalid,
  input logic                                        out_tready,
  input logic [((2 * ADDR_BITS + 16 + 7) / 8) * 8 - 1:0] out_tdata,
  input logic [2:0]                                  out_tuser
);

  logic [wbps_pkg::COUNT_W-1:0] count;

  assign count = out_tdata[ADDR_BITS +: wbps_pkg::COUNT_W];

  // a stalled result beat holds
  `WBPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // a counted match implies a nonzero count and a recorded first match
  `WBPS_ASSERT_NOW(a_hit_counted, clk, rst_n, out_tvalid && out_tuser[0],
    out_tuser[1] && (count != '0))

  // first_valid tracks a nonzero count
  `WBPS_ASSERT_NOW(a_first_valid, clk, rst_n, out_tvalid,
    out_tuser[1] == (count != '0))

  // limit is at least one, so no match means limit not reached
  `WBPS_ASSERT_NOW(a_limit_needs_match, clk, rst_n, out_tvalid && !out_tuser[1],
    !out_tuser[2])

endmodule

bind wildcard_byte_pattern_scanner wbps_check #(
  .ADDR_BITS (ADDR_BITS)
) u_wbps_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
